>>> src/pcmrc_pkg.sv
// pcmrc_pkg: shared types and constants for the 2:3 / 3:2 pcm rate converter
// used by pcmrc_calc, pcm_rate_converter_2to3_3to2_core and pcmrc_checker
// no dependencies
`default_nettype none

package pcmrc_pkg;

   // sample width of the pcm stream
   localparam int SAMPLE_BITS = 16;

   // convert_mode codes
   localparam logic MODE_UP   = 1'b0;
   localparam logic MODE_DOWN = 1'b1;

   // phase codes within a pair or group
   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;

   // result counts per input beat
   localparam logic [1:0] COUNT_NONE = 2'd0;
   localparam logic [1:0] COUNT_ONE  = 2'd1;
   localparam logic [1:0] COUNT_TWO  = 2'd2;

   // divide by three as multiply by reciprocal: magnitudes below 2^(SAMPLE_BITS+1)
   // stay exact with shift SAMPLE_BITS+2 and a rounded-up multiplier
   localparam int DIV3_SHIFT = SAMPLE_BITS + 2;
   localparam int DIV3_FULL  = ((2 ** DIV3_SHIFT) + 2) / 3;
   localparam logic [SAMPLE_BITS:0] DIV3_MULT = DIV3_FULL[SAMPLE_BITS:0];

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          block_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          last_of_block;
   } rsp_type;

   // converter state carried between beats
   typedef struct packed {
      logic [1:0] phase;
      sample_type held_first;
      sample_type held_second;
   } conv_state_type;

   // what one input beat produces
   typedef struct packed {
      logic [1:0]     count;
      rsp_type        first;
      rsp_type        second;
      conv_state_type next_state;
   } calc_result_type;

endpackage

`default_nettype wire

>>> src/pcmrc_calc.sv
// pcmrc_calc: combinational datapath for one input beat of the rate converter
// computes up to two results and the next phase and held samples
// depends on pcmrc_pkg
`default_nettype none

module pcmrc_calc
   import pcmrc_pkg::*;
(
   input  wire logic            mode,
   input  conv_state_type       state,
   input  req_type              item,
   output calc_result_type      result
);

   localparam int W = SAMPLE_BITS;

   // signed divide by three, truncating toward zero
   function automatic sample_type div3(input logic [W+1:0] s);
      logic            neg;
      logic [W+1:0]    mag_full;
      logic [W:0]      mag;
      logic [2*W+1:0]  prod;
      logic [W:0]      q;
      logic [W:0]      q_signed;
      neg      = s[W+1];
      mag_full = neg ? (~s + 1'b1) : s;
      mag      = mag_full[W:0];
      prod     = {{(W+1){1'b0}}, mag} * {{(W+1){1'b0}}, DIV3_MULT};
      q        = prod[DIV3_SHIFT +: (W+1)];
      q_signed = neg ? (~q + 1'b1) : q;
      return q_signed[W-1:0];
   endfunction

   logic [W+1:0] sum_hx2;
   logic [W+1:0] sum_h2x;
   logic [W+1:0] div3_arg;
   sample_type   div3_q;
   logic [W:0]   sum_pair;
   logic [W:0]   sum_pair_adj;
   sample_type   mean_q;
   sample_type   x;
   logic         blk_end;

   assign x       = item.sample_in;
   assign blk_end = item.block_end;

   // interpolation sums: h + 2x and 2h + x
   assign sum_hx2 = {{2{state.held_first[W-1]}}, state.held_first} + {x[W-1], x, 1'b0};
   assign sum_h2x = {state.held_first[W-1], state.held_first, 1'b0} + {{2{x[W-1]}}, x};

   // one shared divide by three, phase picks the sum
   assign div3_arg = (state.phase == PHASE_2) ? sum_h2x : sum_hx2;
   assign div3_q   = div3(div3_arg);

   // mean of two samples, truncating toward zero
   assign sum_pair     = {state.held_second[W-1], state.held_second} + {x[W-1], x};
   assign sum_pair_adj = sum_pair + {{W{1'b0}}, sum_pair[W]};
   assign mean_q       = sum_pair_adj[W:1];

   // phase sequencing and result selection
   always_comb begin
      result                        = '0;
      result.count                  = COUNT_NONE;
      result.next_state             = state;
      if (mode == MODE_UP) begin
         unique case (state.phase)
            PHASE_1: begin
               result.first.sample_out = div3_q;
               if (blk_end) begin
                  result.count                    = COUNT_TWO;
                  result.second.sample_out        = x;
                  result.second.last_of_block     = 1'b1;
                  result.next_state.phase         = PHASE_0;
               end else begin
                  result.count                    = COUNT_ONE;
                  result.next_state.held_first    = x;
                  result.next_state.phase         = PHASE_2;
               end
            end
            PHASE_2: begin
               result.count                    = COUNT_TWO;
               result.first.sample_out         = div3_q;
               result.second.sample_out        = x;
               result.second.last_of_block     = blk_end;
               result.next_state.held_first    = x;
               result.next_state.phase         = blk_end ? PHASE_0 : PHASE_1;
            end
            default: begin
               result.count                    = COUNT_ONE;
               result.first.sample_out         = x;
               result.first.last_of_block      = blk_end;
               result.next_state.held_first    = x;
               result.next_state.phase         = blk_end ? PHASE_0 : PHASE_1;
            end
         endcase
      end else begin
         unique case (state.phase)
            PHASE_1: begin
               result.next_state.held_second   = x;
               result.next_state.phase         = blk_end ? PHASE_0 : PHASE_2;
            end
            PHASE_2: begin
               result.count                    = COUNT_TWO;
               result.first.sample_out         = state.held_first;
               result.second.sample_out        = mean_q;
               result.second.last_of_block     = blk_end;
               result.next_state.phase         = PHASE_0;
            end
            default: begin
               result.next_state.held_first    = x;
               result.next_state.phase         = blk_end ? PHASE_0 : PHASE_1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> src/pcm_rate_converter_2to3_3to2_core.sv
// pcm_rate_converter_2to3_3to2_core: top level of the 2:3 / 3:2 pcm rate converter
// input register, pcmrc_calc datapath, two-entry result register
// depends on pcmrc_pkg and pcmrc_calc
//
//   channel | direction | payload   | handshake
//   req     | in        | req_type  | req_valid / req_ready
//   rsp     | out       | rsp_type  | rsp_valid / rsp_ready
//   csr     | in        | 1 bit     | csr_valid / csr_ready (always ready)
//
// an accepted beat waits in the input register until its results can load the result
// register, which drives rsp; beats with zero or one result go at one per cycle while
// rsp is ready, a beat with two results holds the next until its first is taken, as the
// single rsp port drains the two-entry result register one beat a cycle
// reset clears mode, phase, held samples and both valid states
// a stalled rsp holds its beat; req keeps accepting while the input register can move
`default_nettype none

module pcm_rate_converter_2to3_3to2_core
   import pcmrc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type   rsp_data,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic csr_data
);

   logic            mode_ff, mode_in;
   conv_state_type  state_ff, state_in;
   logic            in_valid_ff, in_valid_in;
   req_type         in_data_ff;
   logic [1:0]      out_count_ff, out_count_in;
   rsp_type         slot0_ff, slot0_in;
   rsp_type         slot1_ff, slot1_in;
   calc_result_type calc_res;
   logic            fire;
   logic            csr_write;
   logic            rsp_take;

   pcmrc_calc u_calc (
      .mode   (mode_ff),
      .state  (state_ff),
      .item   (in_data_ff),
      .result (calc_res)
   );

   // handshakes
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign fire      = in_valid_ff &&
                      ((out_count_ff == COUNT_NONE) ||
                       ((out_count_ff == COUNT_ONE) && rsp_ready));
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = (out_count_ff != COUNT_NONE);
   assign rsp_data  = slot0_ff;

   // input register
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   // mode and converter state, a mode write restarts the phase
   always_comb begin
      mode_in  = mode_ff;
      state_in = state_ff;
      if (fire) begin
         state_in = calc_res.next_state;
      end
      if (csr_write) begin
         mode_in        = csr_data;
         state_in.phase = PHASE_0;
      end
   end

   // result register: load on fire, else shift out one beat per take
   always_comb begin
      out_count_in = out_count_ff;
      slot0_in     = slot0_ff;
      slot1_in     = slot1_ff;
      if (fire) begin
         out_count_in = calc_res.count;
         slot0_in     = calc_res.first;
         slot1_in     = calc_res.second;
      end else if (rsp_take) begin
         out_count_in = out_count_ff - 2'd1;
         slot0_in     = slot1_ff;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UP;
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_count_ff <= COUNT_NONE;
      end else begin
         mode_ff      <= mode_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_count_ff <= out_count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_data_ff <= req_data;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

>>> src/pcmrc_checker.sv
// pcmrc_checker: port-level assertions for pcm_rate_converter_2to3_3to2_core
// bound to the top level at the end of this file
// depends on pcmrc_pkg
`default_nettype none

module pcmrc_checker
   import pcmrc_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input req_type   req_data,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input rsp_type   rsp_data,
   input wire logic csr_valid,
   input wire logic csr_ready,
   input wire logic csr_data
);

   // a stalled result beat holds
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // reset leaves no result pending
   rsp_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // the input side only stalls behind a pending result
   req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req stalled with no result pending");

endmodule

bind pcm_rate_converter_2to3_3to2_core pcmrc_checker u_pcmrc_checker (.*);

`default_nettype wire

>>> sim/pcmrc_scoreboard.sv
// pcmrc_tb_pkg: scoreboard class for the 2:3 / 3:2 pcm rate converter testbench
// predicts result beats from accepted input beats and checks them in order
// depends on pcmrc_pkg
package pcmrc_tb_pkg;

   import pcmrc_pkg::*;

   class rate_conv_scoreboard;

      // predictor copy of the converter state
      logic       conv_mode;
      logic [1:0] phase;
      sample_type held_first;
      sample_type held_second;

      // result beats still owed by the block, oldest first
      rsp_type    owed_results[$];

      int         beats_in;
      int         beats_out;
      int         mismatch_count;

      function new();
         conv_mode      = MODE_UP;
         phase          = PHASE_0;
         held_first     = '0;
         held_second    = '0;
         beats_in       = 0;
         beats_out      = 0;
         mismatch_count = 0;
      endfunction

      // a mode write drops any partial pair or group, held samples stay
      function void write_mode(logic mode_bit);
         conv_mode = mode_bit;
         phase     = PHASE_0;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      function void owe_sample(int value, logic last);
         rsp_type beat;
         beat.sample_out    = value[SAMPLE_BITS-1:0];
         beat.last_of_block = last;
         owed_results.push_back(beat);
      endfunction

      // work out the results of one accepted input beat
      function void note_input(req_type beat);
         int   x;
         int   h1;
         int   h2;
         logic block_end;
         x         = int'(sample_type'(beat.sample_in));
         h1        = int'(held_first);
         h2        = int'(held_second);
         block_end = beat.block_end;
         beats_in++;
         if (conv_mode == MODE_UP) begin
            // interpolate at one-third steps, also emit the last sample at a block end
            case (phase)
               PHASE_1: begin
                  owe_sample((h1 + 2 * x) / 3, 1'b0);
                  if (block_end) begin
                     owe_sample(x, 1'b1);
                     phase = PHASE_0;
                  end else begin
                     held_first = sample_type'(x);
                     phase      = PHASE_2;
                  end
               end
               PHASE_2: begin
                  owe_sample((2 * h1 + x) / 3, 1'b0);
                  owe_sample(x, block_end);
                  held_first = sample_type'(x);
                  phase      = block_end ? PHASE_0 : PHASE_1;
               end
               default: begin
                  owe_sample(x, block_end);
                  held_first = sample_type'(x);
                  phase      = block_end ? PHASE_0 : PHASE_1;
               end
            endcase
         end else begin
            // keep the first sample, average the other two
            case (phase)
               PHASE_1: begin
                  held_second = sample_type'(x);
                  phase       = block_end ? PHASE_0 : PHASE_2;
               end
               PHASE_2: begin
                  owe_sample(h1, 1'b0);
                  owe_sample((h2 + x) / 2, block_end);
                  phase = PHASE_0;
               end
               default: begin
                  held_first = sample_type'(x);
                  phase      = block_end ? PHASE_0 : PHASE_1;
               end
            endcase
         end
      endfunction

      task report_mismatch(string msg);
         if (mismatch_count < 40)
            $display("mismatch: %s", msg);
         mismatch_count++;
      endtask

      // compare one result beat with the oldest owed one
      task check_result(rsp_type got);
         rsp_type want;
         beats_out++;
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("result beat %0d (%0d) with nothing owed",
                                      beats_out, $signed(got.sample_out)));
         end else begin
            want = owed_results.pop_front();
            if (got.sample_out !== want.sample_out)
               report_mismatch($sformatf("result beat %0d: sample_out %0d, wanted %0d",
                                         beats_out, $signed(got.sample_out),
                                         $signed(want.sample_out)));
            if (got.last_of_block !== want.last_of_block)
               report_mismatch($sformatf("result beat %0d: last_of_block %b, wanted %b",
                                         beats_out, got.last_of_block,
                                         want.last_of_block));
         end
      endtask

   endclass

endpackage

>>> sim/testbench.sv
// testbench: stimulus, monitors and run control for pcm_rate_converter_2to3_3to2_core
// directed blocks in both modes, then random blocks under four idling profiles
// depends on pcmrc_pkg, pcmrc_tb_pkg and the core rtl
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import pcmrc_pkg::*;
   import pcmrc_tb_pkg::*;

   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int SEGMENT_BEATS = 128;
   localparam int TIMEOUT_NS    = 2_000_000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data  = 1'b0;

   int      send_idle_pct = 0;
   int      stall_pct     = 0;
   logic    hold_armed    = 1'b0;
   int      hold_left     = 0;

   rate_conv_scoreboard sb = new();

   pcm_rate_converter_2to3_3to2_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d result beats still owed", sb.pending());
      $display("[pcm_rate_converter_2to3_3to2_core] ERROR");
      $finish;
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_armed) begin
         hold_left = HOLD_CYCLES;
         hold_armed <= 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor: every handshake seen at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
         if (req_valid && req_ready)
            sb.note_input(req_data);
         if (csr_valid && csr_ready)
            sb.write_mode(csr_data);
      end
   end

   // offer one sample beat, leaving valid high after acceptance
   task automatic send_beat(input sample_type sample, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_data.sample_in <= sample;
      req_data.block_end <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // stop offering and wait for every owed result, then let the pipe settle
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input logic mode_bit);
      csr_valid <= 1'b1;
      csr_data  <= mode_bit;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly random content with a share of extremes and values near zero
   function automatic sample_type pick_sample();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0:       return sample_type'(-32768);
         1:       return sample_type'(32767);
         2:       return sample_type'(int'($urandom_range(6)) - 3);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // mostly short blocks so that pairs and groups often end part way
   function automatic int pick_len();
      int sel;
      sel = $urandom_range(99);
      if (sel < 80)
         return $urandom_range(6, 1);
      else if (sel < 95)
         return $urandom_range(16, 7);
      else
         return $urandom_range(40, 17);
   endfunction

   // one random stretch in a given mode and idling profile
   task automatic run_random(input logic mode_bit, input int idle, input int stall,
                             input bit with_hold, input bit with_pause);
      int sent;
      int len;
      sent = 0;
      wait_drain();
      write_mode(mode_bit);
      send_idle_pct = idle;
      stall_pct <= stall;
      while (sent < SEGMENT_BEATS) begin
         len = pick_len();
         for (int k = 0; k < len && sent < SEGMENT_BEATS; k++) begin
            if (with_hold && sent == SEGMENT_BEATS / 4)
               hold_armed <= 1'b1;
            if (with_pause && sent == SEGMENT_BEATS / 2)
               wait_drain();
            send_beat(pick_sample(), k == len - 1);
            sent++;
         end
      end
   endtask

   // main sequence
   initial begin
      int idle_by_profile[4];
      int stall_by_profile[4];
      idle_by_profile  = '{0, 77, 0, 20};
      stall_by_profile = '{0, 0, 77, 20};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // upsampling: one-sample block, block ending on each phase, truncation near zero
      write_mode(MODE_UP);
      send_beat(32767, 1'b1);
      send_beat(-32768, 1'b0);
      send_beat(32767, 1'b1);
      send_beat(32767, 1'b0);
      send_beat(-32768, 1'b0);
      send_beat(-32768, 1'b1);
      send_beat(0, 1'b0);
      send_beat(-1, 1'b0);
      send_beat(-2, 1'b0);
      send_beat(1, 1'b1);
      wait_drain();

      // downsampling: extremes, blocks ending with no result, abandoned group
      write_mode(MODE_DOWN);
      send_beat(-32768, 1'b0);
      send_beat(-32768, 1'b0);
      send_beat(-32767, 1'b1);
      send_beat(5, 1'b1);
      send_beat(7, 1'b0);
      send_beat(-3, 1'b1);
      send_beat(1, 1'b0);
      send_beat(2, 1'b0);
      wait_drain();
      write_mode(MODE_DOWN);
      send_beat(32767, 1'b0);
      send_beat(32767, 1'b0);
      send_beat(32767, 1'b0);
      send_beat(-1, 1'b0);
      send_beat(0, 1'b0);
      send_beat(-1, 1'b1);

      // random blocks, each idling profile in both modes
      for (int p = 0; p < 4; p++) begin
         run_random(MODE_UP, idle_by_profile[p], stall_by_profile[p], p == 0, 1'b0);
         run_random(MODE_DOWN, idle_by_profile[p], stall_by_profile[p], 1'b0, p == 1);
      end
      wait_drain();

      $display("covered %0d input beats and %0d result beats in both modes,",
               sb.beats_in, sb.beats_out);
      $display("four idling profiles, a long result hold-off and a full drain pause");
      if (sb.mismatch_count == 0)
         $display("[pcm_rate_converter_2to3_3to2_core] OK");
      else
         $display("[pcm_rate_converter_2to3_3to2_core] ERROR");
      $finish;
   end

endmodule
